// File: sv/sirc_pkg.sv
// Shared types and constants of the stepper injection ramp controller.
`default_nettype none
package sirc_pkg;

  localparam int unsigned WidthW     = 20;
  localparam int unsigned StepW      = 24;
  localparam int unsigned PeriodW    = 16;
  localparam int unsigned PressW     = 16;
  localparam int unsigned CheckW     = 7;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 24;

  localparam logic [CheckW-1:0] CHECK_PERIOD = 7'd100;

  localparam logic [WidthW-1:0] START_WIDTH_RST  = 20'd1000;
  localparam logic [WidthW-1:0] TARGET_WIDTH_RST = 20'd100;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } sirc_op_t;

  typedef enum logic [1:0] {
    STOP_NONE   = 2'd0,
    STOP_LIMIT  = 2'd1,
    STOP_SAFETY = 2'd2,
    STOP_GOAL   = 2'd3
  } sirc_stop_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_START_WIDTH  = 3'd0,
    REG_TARGET_WIDTH = 3'd1,
    REG_RAMP_PERIOD  = 3'd2,
    REG_RAMP_DEC     = 3'd3,
    REG_STEP_LIMIT   = 3'd4,
    REG_SAFETY_PRESS = 3'd5,
    REG_GOAL_PRESS   = 3'd6
  } sirc_reg_t;

  typedef struct packed {
    logic [WidthW-1:0]  start_pulse_width;
    logic [WidthW-1:0]  target_pulse_width;
    logic [PeriodW-1:0] ramp_period_steps;
    logic [PeriodW-1:0] ramp_decrement;
    logic [StepW-1:0]   step_limit;
    logic [PressW-1:0]  safety_pressure;
    logic [PressW-1:0]  goal_pressure;
  } sirc_cfg_t;

  typedef struct packed {
    logic              step_issued;
    logic [WidthW-1:0] pulse_width;
    logic [StepW-1:0]  steps_done;
    logic              run_active;
    logic [1:0]        stop_code;
    logic [PressW-1:0] last_pressure;
  } sirc_result_t;

endpackage
`default_nettype wire

// File: sv/sirc_if.sv
// Valid/ready channel interfaces for start commands, step slots and results.
`default_nettype none
interface sirc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        pressure_valid;
  logic [15:0] pressure_sample;

  modport source (output valid, output operation, output pressure_valid,
                  output pressure_sample, input ready);
  modport sink   (input valid, input operation, input pressure_valid,
                  input pressure_sample, output ready);
endinterface

interface sirc_out_if;
  logic        valid;
  logic        ready;
  logic        step_issued;
  logic [19:0] pulse_width;
  logic [23:0] steps_done;
  logic        run_active;
  logic [1:0]  stop_code;
  logic [15:0] last_pressure;

  modport source (output valid, output step_issued, output pulse_width,
                  output steps_done, output run_active, output stop_code,
                  output last_pressure, input ready);
  modport sink   (input valid, input step_issued, input pulse_width,
                  input steps_done, input run_active, input stop_code,
                  input last_pressure, output ready);
endinterface
`default_nettype wire

// File: sv/stepper_injection_ramp_controller.sv
// Stepper injection ramp controller: start commands and step slots in, one result per item out.
//
// The cmd channel carries one item per transfer: a start command (operation 0)
// that clears the run state and begins a run, or a step slot (operation 1) with
// an optional pressure sample. The result channel returns exactly one transfer
// per accepted item: whether a step was issued, its half-period, the step count,
// whether the run goes on, the stop reason and the last accepted pressure.
// The result of an item is valid in the cycle after its transfer. Throughput
// is one item per cycle while the receiver takes each result; the whole slot
// update (ramp, step limit, pressure check) is one pass of counters and
// compares between the run state registers and the result register.
// When the receiver stalls, the result register holds its value and cmd.ready
// drops until that result has been taken, so no result is lost or repeated.
// Configuration registers are written through cfg_wr_en / cfg_index / cfg_wdata,
// by the user only while no item is in flight, not enforced by the block; a write
// takes effect on the next item. Synchronous reset (rst) loads the register reset
// values, clears the run state, stops any run and empties the result register.
`default_nettype none
module stepper_injection_ramp_controller (
  input  wire logic                            clk,
  input  wire logic                            rst,
  sirc_in_if.sink                              cmd,
  sirc_out_if.source                           result,
  input  wire logic                            cfg_wr_en,
  input  wire logic [sirc_pkg::CfgIndexW-1:0]  cfg_index,
  input  wire logic [sirc_pkg::CfgDataW-1:0]   cfg_wdata
);
  import sirc_pkg::*;

  sirc_cfg_t    cfg;
  sirc_result_t slot_result;
  logic         can_load;
  logic         fire;

  // An item is taken whenever the result register is free or being emptied.
  assign cmd.ready = can_load;
  assign fire      = cmd.valid && can_load;

  sirc_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  sirc_core u_core (
    .clk             (clk),
    .rst             (rst),
    .load            (fire),
    .operation       (cmd.operation),
    .pressure_valid  (cmd.pressure_valid),
    .pressure_sample (cmd.pressure_sample),
    .cfg             (cfg),
    .result          (slot_result)
  );

  sirc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .result   (slot_result),
    .can_load (can_load),
    .rsp      (result)
  );

  // A run that goes on never carries a stop reason.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.run_active |-> result.stop_code == STOP_NONE)
    else $error("active run reports a stop reason");

  // The step count never wraps, so an issued step leaves a nonzero count.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.step_issued |-> result.steps_done != '0)
    else $error("issued step with zero step count");

  // A start command opens a fresh run in the next result.
  assert property (@(posedge clk) disable iff (rst)
    fire && (cmd.operation == OP_START) |=>
      result.valid && result.run_active && (result.steps_done == '0))
    else $error("start command did not open a fresh run");

endmodule
`default_nettype wire

// File: sv/sirc_cfg_regs.sv
// Configuration register file written through the plain write port.
`default_nettype none
module sirc_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [sirc_pkg::CfgIndexW-1:0]  index,
  input  wire logic [sirc_pkg::CfgDataW-1:0]   wdata,
  output sirc_pkg::sirc_cfg_t                  cfg
);
  import sirc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_pulse_width  <= START_WIDTH_RST;
      cfg.target_pulse_width <= TARGET_WIDTH_RST;
      cfg.ramp_period_steps  <= '0;
      cfg.ramp_decrement     <= '0;
      cfg.step_limit         <= '0;
      cfg.safety_pressure    <= '1;
      cfg.goal_pressure      <= '1;
    end else if (wr_en) begin
      case (sirc_reg_t'(index))
        REG_START_WIDTH:  cfg.start_pulse_width  <= wdata[WidthW-1:0];
        REG_TARGET_WIDTH: cfg.target_pulse_width <= wdata[WidthW-1:0];
        REG_RAMP_PERIOD:  cfg.ramp_period_steps  <= wdata[PeriodW-1:0];
        REG_RAMP_DEC:     cfg.ramp_decrement     <= wdata[PeriodW-1:0];
        REG_STEP_LIMIT:   cfg.step_limit         <= wdata[StepW-1:0];
        REG_SAFETY_PRESS: cfg.safety_pressure    <= wdata[PressW-1:0];
        REG_GOAL_PRESS:   cfg.goal_pressure      <= wdata[PressW-1:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/sirc_core.sv
// Run state registers and the per-slot next-state logic.
`default_nettype none
module sirc_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire logic                         operation,
  input  wire logic                         pressure_valid,
  input  wire logic [sirc_pkg::PressW-1:0]  pressure_sample,
  input  wire sirc_pkg::sirc_cfg_t          cfg,
  output sirc_pkg::sirc_result_t            result
);
  import sirc_pkg::*;

  logic [StepW-1:0]   step_counter, step_counter_next;
  logic [PeriodW-1:0] ramp_phase, ramp_phase_next;
  logic [CheckW-1:0]  check_phase, check_phase_next;
  logic [WidthW-1:0]  current_width, current_width_next;
  logic [PressW-1:0]  held_pressure, held_pressure_next;
  logic               active, active_next;
  sirc_stop_t         stop_state, stop_state_next;

  logic               issued;
  logic [WidthW-1:0]  width_out;
  logic [PeriodW-1:0] ramp_inc;
  logic [CheckW-1:0]  check_inc;
  logic [WidthW:0]    ramp_floor;
  logic               check_due;

  always_comb begin
    step_counter_next  = step_counter;
    ramp_phase_next    = ramp_phase;
    check_phase_next   = check_phase;
    current_width_next = current_width;
    held_pressure_next = held_pressure;
    active_next        = active;
    stop_state_next    = stop_state;
    issued             = 1'b0;
    width_out          = current_width;
    ramp_inc           = ramp_phase + 1'b1;
    check_inc          = check_phase + 1'b1;
    ramp_floor         = {1'b0, cfg.target_pulse_width}
                         + {{(WidthW + 1 - PeriodW){1'b0}}, cfg.ramp_decrement};
    check_due          = (check_inc >= CHECK_PERIOD);

    if (sirc_op_t'(operation) == OP_START) begin
      step_counter_next  = '0;
      ramp_phase_next    = '0;
      check_phase_next   = '0;
      current_width_next = cfg.start_pulse_width;
      held_pressure_next = '0;
      active_next        = 1'b1;
      stop_state_next    = STOP_NONE;
      width_out          = cfg.start_pulse_width;
    end else if (active) begin
      if (step_counter >= cfg.step_limit) begin
        stop_state_next = STOP_LIMIT;
        active_next     = 1'b0;
      end else begin
        issued            = 1'b1;
        step_counter_next = step_counter + 1'b1;
        // Ramp: the floor is one bit wider than the width, so it cannot wrap.
        if (cfg.ramp_period_steps == '0) begin
          ramp_phase_next = '0;
        end else if (ramp_inc < cfg.ramp_period_steps) begin
          ramp_phase_next = ramp_inc;
        end else begin
          ramp_phase_next = '0;
          if ({1'b0, current_width} > ramp_floor) begin
            current_width_next = current_width
                                 - {{(WidthW - PeriodW){1'b0}}, cfg.ramp_decrement};
          end else begin
            current_width_next = cfg.target_pulse_width;
          end
        end
        check_phase_next = check_due ? '0 : check_inc;
        if (check_due && pressure_valid) begin
          held_pressure_next = pressure_sample;
          if (pressure_sample >= cfg.safety_pressure) begin
            stop_state_next = STOP_SAFETY;
            active_next     = 1'b0;
          end else if (pressure_sample >= cfg.goal_pressure) begin
            stop_state_next = STOP_GOAL;
            active_next     = 1'b0;
          end
        end
      end
    end

    result.step_issued   = issued;
    result.pulse_width   = width_out;
    result.steps_done    = step_counter_next;
    result.run_active    = active_next;
    result.stop_code     = stop_state_next;
    result.last_pressure = held_pressure_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter  <= '0;
      ramp_phase    <= '0;
      check_phase   <= '0;
      current_width <= START_WIDTH_RST;
      held_pressure <= '0;
      active        <= 1'b0;
      stop_state    <= STOP_NONE;
    end else if (load) begin
      step_counter  <= step_counter_next;
      ramp_phase    <= ramp_phase_next;
      check_phase   <= check_phase_next;
      current_width <= current_width_next;
      held_pressure <= held_pressure_next;
      active        <= active_next;
      stop_state    <= stop_state_next;
    end
  end
endmodule
`default_nettype wire

// File: sv/sirc_out_reg.sv
// Result register that drives the output channel and paces the input side.
`default_nettype none
module sirc_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire sirc_pkg::sirc_result_t result,
  output logic                     can_load,
  sirc_out_if.source               rsp
);
  import sirc_pkg::*;

  logic         valid;
  sirc_result_t held;

  assign can_load = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
    if (load) begin
      held <= result;
    end
  end

  assign rsp.valid         = valid;
  assign rsp.step_issued   = held.step_issued;
  assign rsp.pulse_width   = held.pulse_width;
  assign rsp.steps_done    = held.steps_done;
  assign rsp.run_active    = held.run_active;
  assign rsp.stop_code     = held.stop_code;
  assign rsp.last_pressure = held.last_pressure;
endmodule
`default_nettype wire
